>>> sv/ring_buffer_packet_chunker_macros.svh
// Assertion macros used by the ring buffer chunker datapath.
// Depends on a clock named clk and a synchronous reset named rst in the using module.
`ifndef RING_BUFFER_PACKET_CHUNKER_MACROS_SVH
`define RING_BUFFER_PACKET_CHUNKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RBPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbpc assertion failed");

// Next-cycle implication, checked outside reset.
`define RBPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbpc assertion failed");

// Invariant that holds at every edge outside reset.
`define RBPC_ASSERT_ALW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rbpc assertion failed");

`endif

>>> sv/rbpc_pkg.sv
// Shared types and constants of the ring buffer packet chunker.
// No dependencies; imported by the controller, the datapath and the top.
package rbpc_pkg;

  localparam int BYTE_W           = 8;
  localparam int LEN_W            = 7;
  localparam int DEF_BUFFER_DEPTH = 256;
  localparam int DEF_MAX_CHUNK    = 64;

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              chunk_last;
    logic [LEN_W-1:0]  chunk_length;
    logic              sending;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic push;   // write one byte, step write index
    logic calc;   // fold read index, size the chunk
    logic issue;  // send one entry into the read pipe
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;       // chunk sized as idle result
    logic slot_free;   // read pipe can take an entry this cycle
    logic last_issue;  // one byte left to issue
  } sts_t;

endpackage

>>> sv/rbpc_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
module rbpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/rbpc_ctrl.sv
// Request sequencer of the ring buffer packet chunker.
// Depends on rbpc_pkg.
module rbpc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  input  logic          kind,
  output logic          src_ready,
  output rbpc_pkg::cmd_t cmd,
  input  rbpc_pkg::sts_t sts
);

  import rbpc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CALC  = 3'b010,
    ST_ISSUE = 3'b100
  } state_t;

  state_t state, state_next;
  logic   take;

  assign src_ready = (state == ST_IDLE);
  assign take      = src_valid && src_ready;

  always_comb begin
    cmd.push  = take && (kind == KIND_PUSH);
    cmd.calc  = (state == ST_CALC);
    cmd.issue = (state == ST_ISSUE) && sts.slot_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && (kind == KIND_DRAIN)) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (cmd.issue && (sts.empty || sts.last_issue)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/rbpc_dp.sv
// Datapath of the ring buffer packet chunker: indices, byte store, read pipe.
// Depends on rbpc_pkg, rbpc_ram and the assertion macros header.
`include "ring_buffer_packet_chunker_macros.svh"

module rbpc_dp #(
  parameter int BUFFER_DEPTH = rbpc_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_CHUNK    = rbpc_pkg::DEF_MAX_CHUNK
) (
  input  logic                clk,
  input  logic                rst,
  input  rbpc_pkg::in_item_t  src_item,
  input  rbpc_pkg::cmd_t      cmd,
  output rbpc_pkg::sts_t      sts,
  output logic                res_valid,
  input  logic                res_ready,
  output rbpc_pkg::out_item_t res_item
);

  import rbpc_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int IW = AW + 1;
  localparam int NW = (IW > LEN_W) ? IW : LEN_W;
  localparam logic [IW-1:0] DEPTH_I = IW'(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST_WI = AW'(BUFFER_DEPTH - 1);
  localparam logic [NW-1:0] MAX_N   = NW'(MAX_CHUNK);

  logic [AW-1:0]     wi;
  logic [IW-1:0]     ri;
  logic              send_flag;
  logic              empty;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  rem;

  // read pipe stage: RAM output register plus side info
  logic              q_valid;
  logic              q_last;
  logic              q_idle;
  logic [LEN_W-1:0]  q_len;
  logic              q_send;
  logic              q_move;

  logic [IW-1:0]     ri_f;
  logic [IW-1:0]     wi_x;
  logic              emp;
  logic [IW-1:0]     avail_i;
  logic [NW-1:0]     avail;
  logic [LEN_W-1:0]  n;

  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;

  // chunk sizing
  always_comb begin
    ri_f    = (ri >= DEPTH_I) ? '0 : ri;
    wi_x    = {1'b0, wi};
    emp     = (ri_f == wi_x);
    avail_i = (ri_f > wi_x) ? (DEPTH_I - ri_f) : (wi_x - ri_f);
    avail   = NW'(avail_i);
    n       = (avail > MAX_N) ? LEN_W'(MAX_N) : LEN_W'(avail);
  end

  assign q_move = q_valid && (!res_valid || res_ready);
  assign ram_we = cmd.push;
  assign ram_re = cmd.issue && !empty;

  always_comb begin
    sts.empty      = empty;
    sts.slot_free  = !q_valid || q_move;
    sts.last_issue = (rem == LEN_W'(1));
  end

  rbpc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi),
    .wdata (src_item.data),
    .re    (ram_re),
    .raddr (ri[AW-1:0]),
    .rdata (ram_rdata)
  );

  // indices and chunk bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wi        <= '0;
      ri        <= '0;
      send_flag <= 1'b0;
    end else begin
      if (cmd.push) begin
        wi <= (wi == LAST_WI) ? '0 : wi + AW'(1);
      end
      if (cmd.calc) begin
        ri        <= ri_f;
        send_flag <= !emp;
      end else if (ram_re) begin
        ri <= ri + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      empty <= emp;
      len   <= emp ? '0 : n;
      rem   <= n;
    end else if (ram_re) begin
      rem <= rem - LEN_W'(1);
    end
  end

  // read pipe stage
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (cmd.issue) begin
      q_valid <= 1'b1;
    end else if (q_move) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      q_last <= empty || (rem == LEN_W'(1));
      q_idle <= empty;
      q_len  <= len;
      q_send <= send_flag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_move) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_move) begin
      res_item.out_byte     <= q_idle ? '0 : ram_rdata;
      res_item.chunk_last   <= q_last;
      res_item.chunk_length <= q_len;
      res_item.sending      <= q_send;
    end
  end

  `RBPC_ASSERT_ALW(a_no_rw_clash, !(ram_we && ram_re))
  `RBPC_ASSERT_ALW(a_ri_in_range, ri <= DEPTH_I)
  `RBPC_ASSERT_NXT(a_pipe_holds, q_valid && !q_move, q_valid)
  `RBPC_ASSERT_IMP(a_idle_entry, q_valid && q_idle, q_last && (q_len == '0) && !q_send)

endmodule

>>> sv/ring_buffer_packet_chunker.sv
// Ring buffer packet chunker: push bytes in, drain them out as bounded chunks.
// Drain path: a drain's first result passes sizing, the read stage and the result register.
// Throughput: pushes at 1 per cycle while no drain is in progress; a drain holds
// the input through accept, sizing, then one RAM read per cycle, plus any cycles
// the read stage waits on the output; chunks stream 1 byte per cycle unless stalled.
// Reset (rst, synchronous): clears indices, send flag and valids; store content
// stays undefined until written.
module ring_buffer_packet_chunker #(
  parameter int BUFFER_DEPTH = rbpc_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_CHUNK    = rbpc_pkg::DEF_MAX_CHUNK
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_ready,
  input  rbpc_pkg::in_item_t  src_item,
  output logic                res_valid,
  input  logic                res_ready,
  output rbpc_pkg::out_item_t res_item
);

  import rbpc_pkg::*;

  // Controller only sequences: it takes requests while idle, sizes a drain in its
  // calc state, then issues one entry per free pipe slot.
  cmd_t cmd;
  sts_t sts;

  rbpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .kind      (src_item.kind),
    .src_ready (src_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: write/read indices, byte store, one-entry read stage and the
  // result register. The read stage plus result register let the output stall
  // without losing the RAM's read data, and let a new request be taken while
  // the tail of the previous chunk is still waiting downstream.
  rbpc_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_CHUNK    (MAX_CHUNK)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .src_item  (src_item),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

>>> test/ring_buffer_packet_chunker_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for ring_buffer_packet_chunker: push and drain requests in, chunk
// bytes checked beat by beat against a ring buffer predictor kept in the bench.
// Depends on rbpc_pkg and the chunker RTL only.
module ring_buffer_packet_chunker_tb;
  import rbpc_pkg::*;

  localparam int DEPTH      = DEF_BUFFER_DEPTH;
  localparam int CHUNK_MAX  = DEF_MAX_CHUNK;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int NOISE_MAX  = 6;    // longest run of loose requests between bursts
  localparam int LAP_BASE   = 200;  // lowest write index at which the overrun lap starts
  localparam int IDLE_LIMIT = 500;  // cycles with no handshake on either side
  localparam int TAIL_WAIT  = 16;   // margin after the last expected beat
  localparam int PRINT_MAX  = 20;

  // One queued request plus a pressure mark: a held request is not presented
  // until every outstanding chunk byte has come back.
  typedef struct {
    in_item_t req;
    bit       hold;
  } stim_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_ready;
  in_item_t  src_item  = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  out_item_t res_item;

  stim_t       request_q[$];      // requests not yet presented
  out_item_t   chunk_bytes_q[$];  // beats owed by accepted drains, oldest first
  stim_t       next_req;
  out_item_t   due_beat;
  logic        src_took = 1'b0;   // the request on the bus was taken at the last edge
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  logic [15:0] rx_phase   = '0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count   = 0;
  int unsigned fill_wr      = 0;  // write index as the queued stimulus leaves it

  // Predictor state: byte store, write index (wraps by width), read index that
  // may park at DEPTH until the next drain folds it, and the send flag.
  logic [7:0]       ring_mem[DEPTH];
  logic [PTR_W-1:0] wr_ptr  = '0;
  logic [PTR_W:0]   rd_ptr  = '0;
  logic             tx_flag = 1'b0;

  ring_buffer_packet_chunker #(
    .BUFFER_DEPTH(DEPTH),
    .MAX_CHUNK   (CHUNK_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_item (src_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_item (res_item)
  );

  always #2 clk = ~clk;

  task automatic report_failure(input string msg);
    if (fail_count < PRINT_MAX) $display("[%0t] MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_failure($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Apply one accepted request to the predictor; a drain queues the beats it owes.
  task automatic take_request(input in_item_t req);
    int unsigned rd, wr, avail, n;
    out_item_t   beat;
    if (req.kind == KIND_PUSH) begin
      // no full check: a lapping writer overwrites and can land on the reader
      ring_mem[wr_ptr] = req.data;
      wr_ptr = wr_ptr + 1'b1;
    end else begin
      if (rd_ptr == DEPTH) rd_ptr = '0;  // parked at the end: fold first
      rd = 32'(rd_ptr);
      wr = 32'(wr_ptr);
      if (rd == wr) begin
        tx_flag = 1'b0;
        beat.out_byte     = '0;
        beat.chunk_last   = 1'b1;
        beat.chunk_length = '0;
        beat.sending      = 1'b0;
        chunk_bytes_q.push_back(beat);
      end else begin
        // wrapped data only runs up to the buffer end this time
        avail = (rd > wr) ? DEPTH - rd : wr - rd;
        n = (avail > CHUNK_MAX) ? CHUNK_MAX : avail;
        for (int unsigned i = 0; i < n; i++) begin
          beat.out_byte     = ring_mem[PTR_W'(rd + i)];
          beat.chunk_last   = (i + 1 == n);
          beat.chunk_length = LEN_W'(n);
          beat.sending      = 1'b1;
          chunk_bytes_q.push_back(beat);
        end
        rd_ptr  = (PTR_W + 1)'(rd_ptr + n);
        tx_flag = 1'b1;
      end
    end
  endtask

  task automatic add_push(input logic [7:0] b, input bit hold);
    stim_t s;
    s.req.kind = KIND_PUSH;
    s.req.data = b;
    s.hold     = hold;
    request_q.push_back(s);
    fill_wr = (fill_wr + 1) % DEPTH;
  endtask

  task automatic add_drain(input bit hold);
    stim_t s;
    s.req.kind = KIND_DRAIN;
    s.req.data = 8'($urandom_range(0, 255));  // ignored by the block
    s.hold     = hold;
    request_q.push_back(s);
  endtask

  // k pushes, then enough drains to empty the buffer (noise leftovers included)
  // and one more that should come back idle. Callers keep the burst off the end.
  task automatic add_burst(input int unsigned k, input bit hold);
    for (int unsigned i = 0; i < k; i++) add_push(8'($urandom_range(0, 255)), hold && i == 0);
    repeat ((k + NOISE_MAX + CHUNK_MAX - 1) / CHUNK_MAX + 1) add_drain(1'b0);
  endtask

  // Sender: bursts of random length with random gaps; a held request waits for
  // the result side to go quiet. Valid drops only after a take.
  always @(negedge clk) begin
    if (!rst && (!src_valid || src_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        src_valid <= 1'b0;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].hold && chunk_bytes_q.size() != 0)) begin
        next_req = request_q.pop_front();
        src_item  <= next_req.req;
        src_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // Receiver: phases, picked by rx_phase[9:8], of always ready, coin flips, one slot in eight,
  // and mostly ready.
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    case (rx_phase[9:8])
      2'd0:    res_ready <= 1'b1;
      2'd1:    res_ready <= 1'($urandom_range(0, 1));
      2'd2:    res_ready <= (rx_phase[2:0] == 3'd5);
      default: res_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Monitor: predict on each accepted request, check each accepted beat in order.
  always @(posedge clk) begin
    if (rst) begin
      src_took <= 1'b0;
    end else begin
      src_took <= src_valid && src_ready;
      if (src_valid && src_ready) take_request(src_item);
      if (res_valid && res_ready) begin
        if (chunk_bytes_q.size() == 0) begin
          report_failure($sformatf("beat with nothing outstanding: %p", res_item));
        end else begin
          due_beat = chunk_bytes_q.pop_front();
          check_field("out_byte", 32'(res_item.out_byte), 32'(due_beat.out_byte));
          check_field("chunk_last", 32'(res_item.chunk_last), 32'(due_beat.chunk_last));
          check_field("chunk_length", 32'(res_item.chunk_length),
                      32'(due_beat.chunk_length));
          check_field("sending", 32'(res_item.sending), 32'(due_beat.sending));
        end
      end
    end
  end

  // Watchdog: a stuck handshake on both sides ends the run.
  always @(posedge clk) begin
    if (rst || (src_valid && src_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned k, j;

    // Directed: idle drain after reset, a chunk of extreme bytes, single-byte
    // chunk, push right behind a drain.
    add_drain(1'b0);
    add_push(8'h00, 1'b0);
    add_push(8'hFF, 1'b0);
    add_push(8'h55, 1'b0);
    add_push(8'hAA, 1'b0);
    add_push(8'h01, 1'b0);
    add_push(8'h80, 1'b0);
    add_drain(1'b0);
    add_drain(1'b0);
    add_push(8'h7F, 1'b0);
    add_drain(1'b0);
    add_push(8'hFE, 1'b0);
    add_push(8'h01, 1'b0);
    add_drain(1'b0);
    add_push(8'h33, 1'b0);
    add_drain(1'b0);
    add_drain(1'b0);

    // Random bursts with loose requests between them, kept below the buffer
    // end, until the write index sits high enough for the lap.
    add_burst($urandom_range(CHUNK_MAX + 1, 90), 1'b1);  // full chunk plus a tail
    while (fill_wr < LAP_BASE) begin
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, NOISE_MAX)) begin
          if ($urandom_range(0, 1) != 0) add_drain(1'b0);
          else add_push(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 16);
      if (k > 250 - fill_wr) k = 250 - fill_wr;
      add_burst(k, $urandom_range(0, 4) == 0);
    end

    // Overrun lap from an empty buffer. The writer wraps past the end, so the
    // next drain sees read ahead of write and stops at the buffer end, parking
    // the read index there. More pushes then bring the write index round onto
    // the parked reader: after the fold the buffer looks empty.
    j = $urandom_range(1, 30);
    k = DEPTH - fill_wr + j;
    for (int unsigned i = 0; i < k; i++) add_push(8'($urandom_range(0, 255)), i == 0);
    add_drain(1'b0);
    k = DEPTH - j;
    for (int unsigned i = 0; i < k; i++) add_push(8'($urandom_range(0, 255)), 1'b0);
    add_drain(1'b0);
    add_burst($urandom_range(1, 12), 1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || src_valid || chunk_bytes_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/rbpc_pkg.sv
sv/rbpc_ram.sv
sv/rbpc_ctrl.sv
sv/rbpc_dp.sv
sv/ring_buffer_packet_chunker.sv
test/ring_buffer_packet_chunker_tb.sv
